/* src/scad_pkg.sv */
// Shared types, constants and key tables for the scan code decoder.
package scad_pkg;

   // Field types
   typedef logic [7:0] code_type;
   typedef logic [6:0] index_type;
   typedef logic [2:0] skip_type;

   // Prefix bytes and special key codes
   localparam code_type  PAUSE_PREFIX = 8'hE1;
   localparam code_type  EXT_PREFIX   = 8'hE0;
   localparam code_type  KC_NONE      = 8'h00;
   localparam code_type  KC_PAUSE     = 8'hA0;
   localparam skip_type  SKIP_RESET   = 3'd2;

   // Key indexes with special handling
   localparam index_type IDX_LSHIFT    = 7'd42;
   localparam index_type IDX_RSHIFT    = 7'd54;
   localparam index_type IDX_CAPS      = 7'd58;
   localparam index_type IDX_NUM       = 7'd69;
   localparam index_type IDX_SCROLL    = 7'd70;
   localparam index_type IDX_SYM_FIRST = 7'd2;
   localparam index_type IDX_SYM_LAST  = 7'd53;
   localparam index_type IDX_KP_FIRST  = 7'd71;
   localparam index_type IDX_KP_LAST   = 7'd83;

   localparam code_type  CHAR_A_LOWER  = 8'h61;
   localparam code_type  CHAR_Z_LOWER  = 8'h7A;

   localparam int ROM_ROWS = 89;

   localparam code_type ROM_NORMAL [ROM_ROWS] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h81, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h82, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h83, 8'h2A,
      8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
      8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93,
      8'h94, 8'h95, 8'h2D, 8'h96, 8'h97, 8'h98, 8'h2B, 8'h99,
      8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h00, 8'h00, 8'h00, 8'h9E,
      8'h9F
   };

   localparam code_type ROM_COMBINED [ROM_ROWS] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h81, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h82, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h83, 8'h2A,
      8'h85, 8'h20, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
      8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h37,
      8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
      8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h9E,
      8'h9F
   };

   // Tracked keyboard state
   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic num_on;
      logic scroll_on;
      logic extended_pending;
   } kbd_state_type;

   // Decision for the byte in the input register
   typedef struct packed {
      logic has_result;
      logic is_pause;
      logic key_pressed;
      logic extended_key;
      logic led_update;
      logic caps_led;
      logic num_led;
      logic scroll_led;
   } decode_type;

   // Read one column; rows past the table read as no key
   function automatic code_type rom_read(input logic combined, input index_type idx);
      code_type value;
      value = KC_NONE;
      if (32'(idx) < ROM_ROWS) begin
         value = combined ? ROM_COMBINED[idx] : ROM_NORMAL[idx];
      end
      return value;
   endfunction

endpackage

/* src/scad_if.sv */
// Channel interfaces: scan code input, key result output and register write.
interface scad_req_if;
   logic                valid;
   logic                ready;
   scad_pkg::code_type  scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface scad_rsp_if;
   logic                valid;
   logic                ready;
   scad_pkg::code_type  key_code;
   logic                key_pressed;
   logic                extended_key;
   logic                led_update;
   logic                caps_lock_led;
   logic                num_lock_led;
   logic                scroll_lock_led;

   modport source (output valid, output key_code, output key_pressed, output extended_key,
                   output led_update, output caps_lock_led, output num_lock_led,
                   output scroll_lock_led, input ready);
   modport sink   (input valid, input key_code, input key_pressed, input extended_key,
                   input led_update, input caps_lock_led, input num_lock_led,
                   input scroll_lock_led, output ready);
endinterface

interface scad_csr_if;
   logic                valid;
   logic                ready;
   scad_pkg::skip_type  pause_skip_count;

   modport source (output valid, output pause_skip_count, input ready);
   modport sink   (input valid, input pause_skip_count, output ready);
endinterface

/* src/scad_lookup.sv */
// Key table lookup with shift, caps and num lock column selection.
module scad_lookup #(
   parameter int TABLE_ENTRIES = 89
) (
   input  scad_pkg::index_type     idx,
   input  scad_pkg::kbd_state_type kbd_state,
   output scad_pkg::code_type      key_code
);
   import scad_pkg::*;

   code_type normal_code;
   logic     in_table;
   logic     is_letter;
   logic     use_combined;

   // Limit to the configured table length
   assign in_table    = {1'b0, idx} < 8'(TABLE_ENTRIES);
   assign normal_code = in_table ? rom_read(1'b0, idx) : KC_NONE;
   assign is_letter   = (normal_code >= CHAR_A_LOWER) && (normal_code <= CHAR_Z_LOWER);

   // Letters follow shift xor caps, symbols shift, keypad num lock unless a prefix is pending
   always_comb begin
      priority if (is_letter) begin
         use_combined = kbd_state.shift_held ^ kbd_state.caps_on;
      end else if (idx >= IDX_SYM_FIRST && idx <= IDX_SYM_LAST) begin
         use_combined = kbd_state.shift_held;
      end else if (idx >= IDX_KP_FIRST && idx <= IDX_KP_LAST &&
                   !kbd_state.extended_pending) begin
         use_combined = kbd_state.num_on;
      end else begin
         use_combined = 1'b0;
      end
   end

   assign key_code = !in_table     ? KC_NONE :
                     use_combined  ? rom_read(1'b1, idx) : normal_code;

endmodule

/* src/scad_state.sv */
// Keyboard state registers: shift, locks, extended prefix and pause skipping.
module scad_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  scad_pkg::code_type      code,
   input  logic                    cfg_write,
   input  scad_pkg::skip_type      cfg_data,
   output scad_pkg::kbd_state_type kbd_state,
   output scad_pkg::decode_type    decode
);
   import scad_pkg::*;

   kbd_state_type state_ff, state_in;
   skip_type      skip_ff, skip_in;
   skip_type      skip_cfg_ff, skip_cfg_in;
   index_type     idx;
   logic          down;
   logic          skipping;
   logic          is_pause;
   logic          is_ext;
   logic          led;

   assign idx      = code[6:0];
   assign down     = ~code[7];
   assign skipping = skip_ff != '0;
   assign is_pause = code == PAUSE_PREFIX;
   assign is_ext   = code == EXT_PREFIX;

   // Take register writes
   assign skip_cfg_in = cfg_write ? cfg_data : skip_cfg_ff;

   // Work out the next state for the byte in hand
   always_comb begin
      state_in = state_ff;
      skip_in  = skip_ff;
      led      = 1'b0;
      if (advance) begin
         priority if (skipping) begin
            skip_in = skip_type'(skip_ff - 3'd1);
         end else if (is_pause) begin
            skip_in = skip_cfg_ff;
         end else if (is_ext) begin
            state_in.extended_pending = 1'b1;
         end else begin
            state_in.extended_pending = 1'b0;
            priority if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
               state_in.shift_held = down;
            end else if (idx == IDX_CAPS && down) begin
               state_in.caps_on = ~state_ff.caps_on;
               led              = 1'b1;
            end else if (idx == IDX_NUM && down) begin
               state_in.num_on = ~state_ff.num_on;
               led             = 1'b1;
            end else if (idx == IDX_SCROLL && down) begin
               state_in.scroll_on = ~state_ff.scroll_on;
               led                = 1'b1;
            end else begin
               state_in = state_in;
            end
         end
      end
   end

   // Describe the result for this byte
   always_comb begin
      decode.has_result   = !skipping && !is_ext;
      decode.is_pause     = is_pause;
      decode.key_pressed  = is_pause ? 1'b1 : down;
      decode.extended_key = is_pause ? 1'b0 : state_ff.extended_pending;
      decode.led_update   = led;
      decode.caps_led     = state_in.caps_on;
      decode.num_led      = state_in.num_on;
      decode.scroll_led   = state_in.scroll_on;
   end

   assign kbd_state = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= '0;
         skip_ff     <= '0;
         skip_cfg_ff <= SKIP_RESET;
      end else begin
         state_ff    <= state_in;
         skip_ff     <= skip_in;
         skip_cfg_ff <= skip_cfg_in;
      end
   end

endmodule

/* src/scan_code_to_ascii_decoder.sv */
// Top level of the set-1 scan code to key code decoder.
//
// One scan code byte is taken per req_if transfer. Each byte that is not an
// extended prefix and not swallowed after a pause prefix gives one result on
// rsp_if: a key code, press/release and extended flags, and the lock LED
// states with an update flag when a lock key toggled.
// The byte sits in an input register while the table lookup and state update
// run; the result lands in an output register, from which it is offered on
// rsp_if.
// One byte is taken every cycle while rsp_if does not stall; a byte that gives
// no result leaves the input register even while rsp_if stalls.
// When rsp_if stalls, the output register holds its result and the input
// register holds the next byte; req_if.ready drops once both are full.
// csr_if writes the pause skip count; it is always ready. It is to be written
// only while the decoder is idle; the block itself does not enforce this.
// Reset empties both registers, clears shift, locks, prefix and skip count,
// and sets the pause skip count to two.
module scan_code_to_ascii_decoder #(
   parameter int TABLE_ENTRIES = 89
) (
   input logic         clock,
   input logic         reset,
   scad_req_if.sink    req_if,
   scad_rsp_if.source  rsp_if,
   scad_csr_if.sink    csr_if
);
   import scad_pkg::*;

   logic          in_valid_ff, in_valid_in;
   code_type      in_code_ff, in_code_in;
   logic          out_valid_ff, out_valid_in;
   code_type      key_code_ff, key_code_in;
   decode_type    out_dec_ff, out_dec_in;
   kbd_state_type kbd_state;
   decode_type    decode;
   code_type      table_code;
   logic          out_free;
   logic          advance;
   logic          req_xfer;

   // Handshake
   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign advance       = in_valid_ff && (!decode.has_result || out_free);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_xfer      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   scad_state u_state (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .code      (in_code_ff),
      .cfg_write (csr_if.valid),
      .cfg_data  (csr_if.pause_skip_count),
      .kbd_state (kbd_state),
      .decode    (decode)
   );

   scad_lookup #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_lookup (
      .idx       (in_code_ff[6:0]),
      .kbd_state (kbd_state),
      .key_code  (table_code)
   );

   // Load the input register on a transfer, drop it once processed
   always_comb begin
      in_code_in  = req_xfer ? req_if.scan_code : in_code_ff;
      in_valid_in = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   // Load the output register with a new result, clear it once taken
   always_comb begin
      key_code_in  = key_code_ff;
      out_dec_in   = out_dec_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      if (advance && decode.has_result) begin
         key_code_in  = decode.is_pause ? KC_PAUSE : table_code;
         out_dec_in   = decode;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_code_ff  <= in_code_in;
      key_code_ff <= key_code_in;
      out_dec_ff  <= out_dec_in;
   end

   // Drive the result channel
   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.key_code        = key_code_ff;
   assign rsp_if.key_pressed     = out_dec_ff.key_pressed;
   assign rsp_if.extended_key    = out_dec_ff.extended_key;
   assign rsp_if.led_update      = out_dec_ff.led_update;
   assign rsp_if.caps_lock_led   = out_dec_ff.caps_led;
   assign rsp_if.num_lock_led    = out_dec_ff.num_led;
   assign rsp_if.scroll_lock_led = out_dec_ff.scroll_led;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the set-1 scan code to key code decoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import scad_pkg::*;

   localparam int TABLE_ENTRIES = 89;
   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 120;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 40;

   // One decoded key event as it leaves the block
   typedef struct packed {
      code_type key_code;
      logic     key_pressed;
      logic     extended_key;
      logic     led_update;
      logic     caps_lock_led;
      logic     num_lock_led;
      logic     scroll_lock_led;
   } key_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scad_req_if req_ch ();
   scad_rsp_if rsp_ch ();
   scad_csr_if csr_ch ();

   scan_code_to_ascii_decoder #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Keyboard state as the decoder should hold it
   logic     held_shift   = 1'b0;
   logic     lock_caps    = 1'b0;
   logic     lock_num     = 1'b0;
   logic     lock_scroll  = 1'b0;
   logic     ext_armed    = 1'b0;
   skip_type skip_left    = '0;
   skip_type skip_setting = SKIP_RESET;

   key_event_type pending_keys[$];
   int error_count   = 0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic holding     = 1'b0;
   event hold_go;

   // Clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Work out the event a byte gives and advance the tracked state
   function automatic bit decode_scan_code(input code_type code, output key_event_type ev);
      index_type idx;
      logic      down;
      logic      combined;
      logic      in_table;
      code_type  plain;
      idx  = code[6:0];
      down = !code[7];
      ev   = '0;
      if (skip_left != 0) begin
         skip_left = skip_left - 1'b1;
         return 1'b0;
      end
      if (code == PAUSE_PREFIX) begin
         skip_left          = skip_setting;
         ev.key_code        = KC_PAUSE;
         ev.key_pressed     = 1'b1;
         ev.caps_lock_led   = lock_caps;
         ev.num_lock_led    = lock_num;
         ev.scroll_lock_led = lock_scroll;
         return 1'b1;
      end
      if (code == EXT_PREFIX) begin
         ext_armed = 1'b1;
         return 1'b0;
      end

      // Pick the column: letters follow shift xor caps, symbols shift, keypad num lock unless extended
      in_table = (int'(idx) < TABLE_ENTRIES) && (int'(idx) < ROM_ROWS);
      plain    = in_table ? ROM_NORMAL[idx] : KC_NONE;
      if (plain >= CHAR_A_LOWER && plain <= CHAR_Z_LOWER) begin
         combined = held_shift ^ lock_caps;
      end else if (idx >= IDX_SYM_FIRST && idx <= IDX_SYM_LAST) begin
         combined = held_shift;
      end else if (idx >= IDX_KP_FIRST && idx <= IDX_KP_LAST && !ext_armed) begin
         combined = lock_num;
      end else begin
         combined = 1'b0;
      end
      if (!in_table) begin
         ev.key_code = KC_NONE;
      end else begin
         ev.key_code = combined ? ROM_COMBINED[idx] : plain;
      end
      ev.key_pressed  = down;
      ev.extended_key = ext_armed;
      ext_armed       = 1'b0;

      // Shift follows the key; locks toggle on a press only
      if (idx == IDX_LSHIFT || idx == IDX_RSHIFT) begin
         held_shift = down;
      end else if (down && idx == IDX_CAPS) begin
         lock_caps     = !lock_caps;
         ev.led_update = 1'b1;
      end else if (down && idx == IDX_NUM) begin
         lock_num      = !lock_num;
         ev.led_update = 1'b1;
      end else if (down && idx == IDX_SCROLL) begin
         lock_scroll   = !lock_scroll;
         ev.led_update = 1'b1;
      end
      ev.caps_lock_led   = lock_caps;
      ev.num_lock_led    = lock_num;
      ev.scroll_lock_led = lock_scroll;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_LIMIT) begin
         $display("tb_top: %s mismatch at cycle %0d: got %0h, expected %0h",
                  what, cycle_count, got, want);
      end
      error_count++;
   endtask

   // Offer one byte, with a random gap first, and predict on its transfer
   task automatic send_code(input code_type code);
      key_event_type ev;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.scan_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      if (decode_scan_code(code, ev)) begin
         pending_keys.push_back(ev);
      end
      items_sent++;
   endtask

   // Drop valid and hold until every predicted event has come out
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_skip(input skip_type value);
      wait_for_results();
      csr_ch.valid            <= 1'b1;
      csr_ch.pause_skip_count <= value;
      do @(posedge clock); while (!csr_ch.ready);
      skip_setting = value;
      csr_ch.valid <= 1'b0;
   endtask

   // Edges of the table, the code range and the release bit
   task automatic test_plain_keys();
      code_type seq[];
      seq = '{8'h00, 8'h1E, 8'h9E, 8'h58, 8'hD9, 8'h7F, 8'hFF};
      foreach (seq[i]) send_code(seq[i]);
   endtask

   // Shift on both sides, all three locks, the keypad and extended keys
   task automatic test_shift_and_locks();
      code_type seq[];
      seq = '{8'h2A, 8'h1E, 8'h02, 8'hAA, 8'h3A, 8'hBA, 8'h1E, 8'h36, 8'h0C, 8'hB6,
              8'h45, 8'h47, 8'h53, 8'hC5, 8'h46, 8'hC6, 8'hE0, 8'h47, 8'hE0, 8'h2A,
              8'h10, 8'hE0, 8'hAA};
      foreach (seq[i]) send_code(seq[i]);
   endtask

   // Pause keeps a pending prefix; prefixes inside the skip are swallowed
   task automatic test_pause_prefix();
      code_type seq[];
      seq = '{8'hE0, 8'hE1, 8'h1D, 8'h45, 8'h1C, 8'hE1, 8'hE0, 8'hE1, 8'h1E};
      foreach (seq[i]) send_code(seq[i]);
   endtask

   // Skip lengths 0, 7, 5 and 1, with prefixes and locks inside the skip
   task automatic test_skip_settings();
      skip_type settings[];
      code_type fill[];
      settings = '{3'd0, 3'd7, 3'd5, 3'd1};
      fill     = '{8'hE0, 8'hE1, 8'h2A, 8'h3A, 8'h45, 8'h46, 8'h9E};
      foreach (settings[s]) begin
         write_skip(settings[s]);
         send_code(PAUSE_PREFIX);
         for (int i = 0; i < int'(settings[s]); i++) send_code(fill[i]);
         send_code(8'h1E);
         send_code(8'h9E);
      end
   endtask

   // Hold the receiver off while the sender keeps offering, then drain
   task automatic test_output_hold();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      wait_for_results();
      -> hold_go;
      repeat (40) send_code(code_type'($urandom_range(127)));
      wait_for_results();
   endtask

   // Mostly well-formed key sequences with random content, some noise
   task automatic play_random_keys(input int count);
      int       start;
      int       pick;
      int       n;
      logic     ext;
      code_type key;
      code_type other;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            key   = ($urandom_range(7) == 0) ? code_type'($urandom_range(127)) :
                                               code_type'($urandom_range(88));
            other = code_type'($urandom_range(88));
            ext   = ($urandom_range(3) == 0);
            if (ext) send_code(EXT_PREFIX);
            send_code(key);
            if ($urandom_range(1)) begin
               send_code(other);
               send_code(other | 8'h80);
            end
            if (ext) send_code(EXT_PREFIX);
            send_code(key | 8'h80);
         end else if (pick < 62) begin
            key = $urandom_range(1) ? code_type'(IDX_LSHIFT) : code_type'(IDX_RSHIFT);
            send_code(key);
            n = $urandom_range(1, 3);
            repeat (n) begin
               other = code_type'($urandom_range(2, 53));
               send_code(other);
               send_code(other | 8'h80);
            end
            send_code(key | 8'h80);
         end else if (pick < 72) begin
            case ($urandom_range(2))
               0:       key = code_type'(IDX_CAPS);
               1:       key = code_type'(IDX_NUM);
               default: key = code_type'(IDX_SCROLL);
            endcase
            send_code(key);
            send_code(key | 8'h80);
            other = code_type'($urandom_range(IDX_KP_FIRST, IDX_KP_LAST));
            if ($urandom_range(1)) send_code(EXT_PREFIX);
            send_code(other);
         end else if (pick < 80) begin
            send_code(PAUSE_PREFIX);
            n = $urandom_range(7);
            repeat (n) send_code(code_type'($urandom_range(255)));
         end else begin
            send_code(code_type'($urandom_range(255)));
         end
      end
   endtask

   // Random traffic under each idling pattern, with a new skip length per phase
   task automatic test_random_traffic();
      int sender_pct[];
      int receiver_pct[];
      sender_pct   = '{0, 47, 0, 12};
      receiver_pct = '{0, 0, 47, 12};
      foreach (sender_pct[p]) begin
         write_skip(skip_type'($urandom_range(7)));
         send_idle_pct = sender_pct[p];
         rsp_stall_pct = receiver_pct[p];
         play_random_keys(75);
      end
      wait_for_results();
   endtask

   // Long receiver hold-off, counted here
   always begin
      @(hold_go);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // Receiver ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !holding && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Compare each transfer with the oldest predicted event
   always @(posedge clock) begin
      key_event_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_keys.size() == 0) begin
            report_mismatch("unpredicted result, key_code", rsp_ch.key_code, 0);
         end else begin
            want = pending_keys.pop_front();
            if (rsp_ch.key_code !== want.key_code)
               report_mismatch("key_code", rsp_ch.key_code, want.key_code);
            if (rsp_ch.key_pressed !== want.key_pressed)
               report_mismatch("key_pressed", rsp_ch.key_pressed, want.key_pressed);
            if (rsp_ch.extended_key !== want.extended_key)
               report_mismatch("extended_key", rsp_ch.extended_key, want.extended_key);
            if (rsp_ch.led_update !== want.led_update)
               report_mismatch("led_update", rsp_ch.led_update, want.led_update);
            if (rsp_ch.caps_lock_led !== want.caps_lock_led)
               report_mismatch("caps_lock_led", rsp_ch.caps_lock_led, want.caps_lock_led);
            if (rsp_ch.num_lock_led !== want.num_lock_led)
               report_mismatch("num_lock_led", rsp_ch.num_lock_led, want.num_lock_led);
            if (rsp_ch.scroll_lock_led !== want.scroll_lock_led)
               report_mismatch("scroll_lock_led", rsp_ch.scroll_lock_led,
                               want.scroll_lock_led);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Test sequence
   initial begin
      req_ch.valid            = 1'b0;
      req_ch.scan_code        = '0;
      csr_ch.valid            = 1'b0;
      csr_ch.pause_skip_count = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_keys();
      test_shift_and_locks();
      test_pause_prefix();
      test_skip_settings();
      test_output_hold();
      test_random_traffic();

      wait_for_results();
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
